// ===== src/l2nc_pkg.sv =====
`timescale 1ns / 1ps
package l2nc_pkg;

   localparam int MaxRowLen = 64;
   localparam int IdxW = $clog2(MaxRowLen);
   localparam int LenW = $clog2(MaxRowLen + 1);
   localparam int QueueDepth = 2;
   localparam logic [30:0] ThresholdReset = 31'd65536;
   localparam logic [31:0] FactorOne = 32'd16777216;

   typedef struct packed {
      logic signed [31:0] element_in;
      logic               row_end_in;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] element_out;
      logic               row_end_out;
      logic               was_clipped;
   } rsp_word_type;

   // one finished row handed from front to back
   typedef struct packed {
      logic [63:0]     square_sum;
      logic [LenW-1:0] row_length;
   } row_job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQRT,
      BK_DIV,
      BK_READ,
      BK_EMIT
   } back_state_type;

endpackage

// ===== src/l2nc_ram.sv =====
`timescale 1ns / 1ps
module l2nc_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== src/l2nc_front.sv =====
`timescale 1ns / 1ps
module l2nc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           take,
   input  l2nc_pkg::req_word_type         req_word,
   output logic                           wr_en,
   output logic [l2nc_pkg::IdxW-1:0]      wr_addr,
   output logic [31:0]                    wr_data,
   output logic                           job_push,
   output l2nc_pkg::row_job_type          job
);
   import l2nc_pkg::*;

   logic [63:0]     sum_ff, sum_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [31:0]     mag;
   logic [63:0]     sq;
   logic [64:0]     acc;
   logic [LenW-1:0] len_next;

   always_comb begin
      mag = req_word.element_in[31] ? 32'(-req_word.element_in) : req_word.element_in;
      sq  = 64'(mag) * 64'(mag);
      acc = {1'b0, sum_ff} + {1'b0, sq};
      len_next = len_ff + LenW'(1);
      wr_en   = take;
      wr_addr = len_ff[IdxW-1:0];
      wr_data = req_word.element_in;
      job_push = take && (req_word.row_end_in || len_next == LenW'(MaxRowLen));
      job.square_sum = acc[64] ? '1 : acc[63:0];
      job.row_length = len_next;
      sum_in = sum_ff;
      len_in = len_ff;
      if (take) begin
         sum_in = job_push ? '0 : job.square_sum;
         len_in = job_push ? '0 : len_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         len_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         len_ff <= len_in;
      end
   end
endmodule

// ===== src/l2nc_back.sv =====
`timescale 1ns / 1ps
module l2nc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [30:0]                    threshold,
   input  logic                           job_valid,
   input  l2nc_pkg::row_job_type          job,
   output logic                           job_pop,
   output logic [l2nc_pkg::IdxW-1:0]      rd_addr,
   input  logic [31:0]                    rd_data,
   output logic                           rsp_valid,
   output l2nc_pkg::rsp_word_type         rsp_word
);
   import l2nc_pkg::*;

   back_state_type  state_ff, state_in;
   logic [63:0]     rem_ff, rem_in;
   logic [31:0]     root_ff, root_in;
   logic [5:0]      step_ff, step_in;
   logic [54:0]     num_ff, num_in;
   logic [31:0]     quo_ff, quo_in;
   logic [31:0]     factor_ff, factor_in;
   logic            clip_ff, clip_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [LenW-1:0] k_ff, k_in;
   logic [65:0]     trial;
   logic [32:0]     dsub;
   logic [63:0]     prod;

   always_comb begin
      state_in = state_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      factor_in = factor_ff;
      clip_in = clip_ff;
      len_in = len_ff;
      k_in = k_ff;
      job_pop = 1'b0;
      rsp_valid = 1'b0;
      rd_addr = k_ff[IdxW-1:0];
      trial = '0;
      dsub = '0;
      prod = 64'($signed(rd_data) * $signed({1'b0, factor_ff}));
      rsp_word.element_out = prod[55:24];
      rsp_word.row_end_out = (k_ff + LenW'(1)) == len_ff;
      rsp_word.was_clipped = clip_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               rem_in = job.square_sum;
               len_in = job.row_length;
               root_in = '0;
               num_in = '0;
               step_in = 6'd31;
               state_in = BK_SQRT;
            end
         end
         BK_SQRT: begin
            // restoring root: two bits of the sum per cycle
            trial = 66'({num_ff, rem_ff[63:62]}) - 66'({root_ff, 2'b01});
            if (!trial[65]) begin
               num_in = 55'(trial[64:0]);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               num_in = 55'({num_ff, rem_ff[63:62]});
               root_in = {root_ff[30:0], 1'b0};
            end
            rem_in = {rem_ff[61:0], 2'b00};
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd0) begin
               clip_in = (root_in > {1'b0, threshold}) && (root_in != '0);
               num_in = {threshold, 24'b0};
               rem_in = '0;
               quo_in = '0;
               step_in = 6'd54;
               state_in = clip_in ? BK_DIV : BK_READ;
               factor_in = FactorOne;
               k_in = '0;
            end
         end
         BK_DIV: begin
            // one quotient bit per cycle
            dsub = 33'({rem_ff[31:0], num_ff[54]}) - 33'({1'b0, root_ff});
            num_in = {num_ff[53:0], 1'b0};
            if (!dsub[32]) begin
               rem_in = 64'(dsub[31:0]);
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = 64'({rem_ff[31:0], num_ff[54]});
               quo_in = {quo_ff[30:0], 1'b0};
            end
            step_in = step_ff - 6'd1;
            if (step_ff == 6'd0) begin
               factor_in = quo_in;
               k_in = '0;
               state_in = BK_READ;
            end
         end
         BK_READ: state_in = BK_EMIT;
         BK_EMIT: begin
            rsp_valid = 1'b1;
            k_in = k_ff + LenW'(1);
            rd_addr = k_in[IdxW-1:0];
            state_in = rsp_word.row_end_out ? BK_IDLE : BK_READ;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else state_ff <= state_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      factor_ff <= factor_in;
      clip_ff <= clip_in;
      len_ff <= len_in;
      k_ff <= k_in;
   end
endmodule

// ===== src/l2nc_queue.sv =====
`timescale 1ns / 1ps
module l2nc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  l2nc_pkg::row_job_type push_job,
   input  logic                  pop,
   output logic                  not_empty,
   output logic                  full,
   output l2nc_pkg::row_job_type head_job
);
   import l2nc_pkg::*;

   row_job_type slot_ff [QueueDepth];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;

   assign not_empty = cnt_ff != 2'd0;
   assign full = cnt_ff == 2'(QueueDepth);
   assign head_job = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_job;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== src/l2_norm_row_clipper.sv =====
`timescale 1ns / 1ps
// Flow: the back takes a finished row from the queue in the cycle after its last
// word, computes the root, divides when clipped, then reads and emits each word.
// Rate: one word per cycle in within a row; results never come back to back.
// Busy holds off start while a row is queued or the back still drains one, since the
// row store has one buffer. Reset is synchronous and clears the sums,
// counters and queue; the threshold returns to 1.0. Results cannot stall.
module l2_norm_row_clipper (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  l2nc_pkg::req_word_type req_word,
   input  logic                   csr_wr_en,
   input  logic [30:0]            csr_wr_data,
   output logic                   rsp_strobe,
   output l2nc_pkg::rsp_word_type rsp_word
);
   import l2nc_pkg::*;

   logic [30:0]     thr_ff;
   logic            take, wr_en, job_push, job_pop, q_ne, q_full;
   logic            back_busy;
   logic [IdxW-1:0] wr_addr, rd_addr;
   logic [31:0]     wr_data, rd_data;
   row_job_type     job, head;

   // store has one row: wait until back is idle with no queued row
   assign busy = q_ne || q_full || back_busy;
   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ThresholdReset;
         back_busy <= 1'b0;
      end else begin
         if (csr_wr_en) thr_ff <= csr_wr_data;
         if (job_pop) back_busy <= 1'b1;
         else if (rsp_strobe && rsp_word.row_end_out) back_busy <= 1'b0;
      end
   end

   l2nc_front u_front (.clock, .reset, .take, .req_word, .wr_en, .wr_addr, .wr_data,
      .job_push, .job);
   l2nc_queue u_queue (.clock, .reset, .push(job_push), .push_job(job), .pop(job_pop),
      .not_empty(q_ne), .full(q_full), .head_job(head));
   l2nc_ram #(.Width(32), .Depth(MaxRowLen)) u_ram (.clock, .wr_en, .wr_addr, .wr_data,
      .rd_addr, .rd_data);
   l2nc_back u_back (.clock, .reset, .threshold(thr_ff), .job_valid(q_ne), .job(head),
      .job_pop, .rd_addr, .rd_data, .rsp_valid(rsp_strobe), .rsp_word);
endmodule

// ===== src/l2nc_checker.sv =====
`timescale 1ns / 1ps
module l2nc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   busy,
   input logic                   rsp_strobe,
   input l2nc_pkg::rsp_word_type rsp_word
);
   a_no_strobe_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_strobe) else $error("strobe after reset");
   a_busy_when_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result while not busy");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("back to back results");
   a_clip_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_word.row_end_out ##2 rsp_strobe |->
      rsp_word.was_clipped == $past(rsp_word.was_clipped, 2))
      else $error("clip flag changed in row");
endmodule

bind l2_norm_row_clipper l2nc_checker u_l2nc_checker (.clock, .reset, .busy,
   .rsp_strobe, .rsp_word);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
   import l2nc_pkg::*;

   localparam int TimeoutCycles = 20000;
   localparam int DrainCycles = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_word_type req_word = '0;
   logic csr_wr_en = 1'b0;
   logic [30:0] csr_wr_data = '0;
   logic rsp_strobe;
   rsp_word_type rsp_word;

   l2_norm_row_clipper dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] row_copy [MaxRowLen];
   logic [63:0] sum_sq;
   int unsigned row_len;
   logic [30:0] threshold;

   rsp_word_type scaled_q[$];
   int mismatches = 0;
   int words_in = 0, words_out = 0, rows_done = 0, clipped_rows = 0;
   int idle_cycles = 0;

   function automatic logic [63:0] int_root(input logic [63:0] v);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   task automatic predict_word(input req_word_type w);
      logic signed [63:0] s, p;
      logic [63:0] sq, norm, factor;
      logic clip;
      rsp_word_type r;
      s = 64'(w.element_in);
      sq = (s < 0) ? 64'(-s) * 64'(-s) : 64'(s) * 64'(s);
      if (row_len >= MaxRowLen) row_len = 0;
      row_copy[row_len] = w.element_in;
      row_len++;
      if (sum_sq > ~64'd0 - sq) sum_sq = ~64'd0;
      else sum_sq = sum_sq + sq;
      if (!w.row_end_in && row_len < MaxRowLen) return;
      norm = int_root(sum_sq);
      clip = (norm > 64'(threshold)) && (norm > 0);
      factor = clip ? (64'(threshold) << 24) / norm : 64'd16777216;
      for (int k = 0; k < row_len; k++) begin
         p = 64'($signed(row_copy[k])) * $signed(factor);
         r.element_out = 32'(p >>> 24);
         r.row_end_out = (k + 1 == row_len);
         r.was_clipped = clip;
         scaled_q = {scaled_q, r};
      end
      rows_done++;
      if (clip) clipped_rows++;
      sum_sq = 0;
      row_len = 0;
   endtask

   // check every result word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         words_out++;
         if (scaled_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_word);
         end else begin
            rsp_word_type e;
            e = scaled_q.pop_front();
            if (e !== rsp_word) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp elem %h end %b clip %b, got %h %b %b",
                     e.element_out, e.row_end_out, e.was_clipped,
                     rsp_word.element_out, rsp_word.row_end_out,
                     rsp_word.was_clipped);
            end
         end
      end
   end

   // watchdog on cycles with no accepted word and no result
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= TimeoutCycles) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // start stays high across words sent with no gap
   task automatic send_word(input logic [31:0] elem, input logic last);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= '{element_in: elem, row_end_in: last};
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_word('{element_in: elem, row_end_in: last});
      words_in++;
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (scaled_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [30:0] v);
      wait_drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      threshold = v;
   endtask

   typedef struct {
      logic [31:0] elem;
      logic        last;
      logic        typed;
      logic [31:0] exp_elem;
      logic        exp_clip;
   } stim_row_type;

   stim_row_type directed [] = '{
      // 1.0 equal to reset threshold: unscaled
      '{32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b0},
      // zero norm
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      // -1.0 equal to threshold: not clipped
      '{32'hFFFF_0000, 1'b1, 1'b1, 32'hFFFF_0000, 1'b0},
      // 2.0 -> clipped to 1.0
      '{32'h0002_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b1},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0}
   };

   task automatic random_rows(input int n_words);
      int sent, len;
      logic [31:0] e;
      sent = 0;
      while (sent < n_words) begin
         len = ($urandom_range(0, 15) == 0) ? MaxRowLen + $urandom_range(0, 3)
                                            : $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 3))
               0: e = $urandom();
               1: e = 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000);
               2: e = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
               default: e = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            endcase
            send_word(e, (k == len - 1) || ($urandom_range(0, 30) == 0));
            sent++;
         end
      end
   endtask

   initial begin
      rsp_word_type got;
      sum_sq = 0;
      row_len = 0;
      threshold = ThresholdReset;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].typed) begin
            // single-word row with an expectation read off by hand
            wait_drain();
            send_word(directed[i].elem, directed[i].last);
            got = scaled_q[$];
            if (got.element_out !== directed[i].exp_elem ||
                got.was_clipped !== directed[i].exp_clip) begin
               mismatches++;
               $display("directed row %0d: predictor gives %h, table %h", i,
                  got.element_out, directed[i].exp_elem);
            end
         end else begin
            send_word(directed[i].elem, directed[i].last);
         end
      end
      // full row ended by length, without a row end flag
      for (int k = 0; k < MaxRowLen + 1; k++) send_word($urandom(), 1'b0);
      send_word(32'h0001_0000, 1'b1);

      set_threshold(31'd0);
      random_rows(60);
      set_threshold(31'h7FFF_FFFF);
      random_rows(60);
      set_threshold(31'h0000_8000);
      random_rows(120);
      // hold the sender until every word is out
      wait_drain();
      for (int p = 0; p < 3; p++) begin
         set_threshold(31'($urandom_range(0, 32'h0010_0000)));
         random_rows(80);
      end

      wait_drain();
      $display("Sent %0d words in %0d rows (%0d clipped), checked %0d results.",
         words_in, rows_done, clipped_rows, words_out);
      if (mismatches == 0 && scaled_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
